FILE: rtl/oae_pkg.sv
// oae_pkg: shared types and constants of the order-1 arithmetic encoder.
// Used by oae_div and order1_arith_encoder; depends on nothing.
package oae_pkg;

   localparam int SCALE_W  = 14;   // width of a frequency count
   localparam int RANGE_W  = 17;   // high - low + 1
   localparam int DIV_W    = 31;   // range * count
   localparam int REM_W    = 15;
   localparam int CODE_W   = 16;   // low/high registers
   localparam int FOLLOW_W = 16;

   localparam logic REG_MAX_SCALE = 1'b0;   // csr_paddr[2] of max_scale

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_HI,
      ST_RD_TOP,
      ST_RD_SCALE,
      ST_DIV_HI_GO,
      ST_DIV_HI_WAIT,
      ST_DIV_LO_GO,
      ST_DIV_LO_WAIT,
      ST_RENORM,
      ST_FLUSH,
      ST_WALK,
      ST_DRAIN,
      ST_CHECK
   } state_type;

endpackage

FILE: rtl/oae_div.sv
// oae_div: restoring divider, one quotient bit per cycle.
// Depends on oae_pkg for the operand widths.
module oae_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [oae_pkg::DIV_W-1:0]         dividend,
   input  logic [oae_pkg::SCALE_W-1:0]       divisor,
   output logic                              busy,
   output logic [oae_pkg::DIV_W-1:0]         quotient
);

   localparam int CNT_W = $clog2(oae_pkg::DIV_W);

   logic                            busy_ff, busy_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [oae_pkg::REM_W-1:0]       rem_ff, rem_in;
   logic [oae_pkg::DIV_W-1:0]       quot_ff, quot_in;
   logic [oae_pkg::SCALE_W-1:0]     dvs_ff, dvs_in;
   logic [oae_pkg::REM_W:0]         trial;
   logic [oae_pkg::REM_W:0]         dvs_ext;
   logic                            ge;

   always_comb begin
      trial   = {rem_ff, quot_ff[oae_pkg::DIV_W-1]};
      dvs_ext = (oae_pkg::REM_W+1)'(dvs_ff);
      ge      = trial >= dvs_ext;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quot_in = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? oae_pkg::REM_W'(trial - dvs_ext) : trial[oae_pkg::REM_W-1:0];
         quot_in = {quot_ff[oae_pkg::DIV_W-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(oae_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

endmodule

FILE: rtl/order1_arith_encoder.sv
// order1_arith_encoder: adaptive order-1 arithmetic encoder, top level.
// Depends on oae_pkg and oae_div.
//
// One symbol per req beat (byte, or ALPHABET for end of stream); each beat yields
// runs on rsp (lead bit, count of inverted bits, tlast on the final run of the beat).
// Symbols above ALPHABET are taken and dropped. Frequencies live in one
// single-port-write, registered-read RAM of ALPHABET*(ALPHABET+2) entries. A symbol
// takes table reads, two divisions in the shared bit-serial divider, up to 16
// renormalisation steps, an increment of the counts above the symbol and, when the
// total reaches max_scale, a halving of the row; longer while rsp_tready is low. End of
// stream adds 17 flush runs. After reset and after each end of stream the RAM is
// reloaded one entry a cycle; req_tready stays low meanwhile, CSR writes still land.
module order1_arith_encoder #(
   parameter int ALPHABET      = 256,
   parameter int PENDING_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,     // [8:0] symbol
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,     // [0] lead_bit, [16:1] follow_count
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int ROW   = ALPHABET + 2;
   localparam int DEPTH = ALPHABET * ROW;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(ROW);
   localparam int CW    = $clog2(ALPHABET);
   localparam int PW    = PENDING_WIDTH;
   localparam int SW    = oae_pkg::SCALE_W;
   localparam int LW    = oae_pkg::CODE_W;
   localparam logic [IW-1:0] TOP_IDX   = IW'(ALPHABET + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [8:0]    EOS_SYM   = 9'(ALPHABET);

   oae_pkg::state_type state_ff, state_in;

   logic [8:0]                  sym_ff, sym_in;
   logic                        eos_ff, eos_in;
   logic [AW-1:0]               base_ff, base_in;
   logic [SW-1:0]               lo_c_ff, lo_c_in;
   logic [SW-1:0]               hi_c_ff, hi_c_in;
   logic [SW-1:0]               scale_ff, scale_in;
   logic [oae_pkg::RANGE_W-1:0] range_ff, range_in;
   logic [LW-1:0]               q_hi_ff, q_hi_in;
   logic [LW-1:0]               low_ff, low_in;
   logic [LW-1:0]               high_ff, high_in;
   logic [PW-1:0]               pend_ff, pend_in;
   logic [CW-1:0]               prev_ff, prev_in;
   logic [4:0]                  step_ff, step_in;
   logic [4:0]                  fcnt_ff, fcnt_in;
   logic [IW-1:0]               idx_ff, idx_in;
   logic                        wr_vld_ff, wr_vld_in;
   logic [IW-1:0]               wr_idx_ff, wr_idx_in;
   logic                        half_ff, half_in;
   logic [SW-1:0]               hprev_ff, hprev_in;
   logic [SW-1:0]               total_ff, total_in;
   logic [AW-1:0]               clr_addr_ff, clr_addr_in;
   logic [IW-1:0]               clr_idx_ff, clr_idx_in;
   logic [SW-1:0]               max_scale_ff, max_scale_in;
   logic                        rsp_vld_ff, rsp_vld_in;
   logic                        rsp_lead_ff, rsp_lead_in;
   logic [oae_pkg::FOLLOW_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic                        rsp_last_ff, rsp_last_in;

   // frequency RAM
   logic [SW-1:0] freq_mem [DEPTH];
   logic [SW-1:0] rdata_ff;
   logic [AW-1:0] mem_raddr, mem_waddr;
   logic [SW-1:0] mem_wdata;
   logic          mem_we;

   // divider
   logic                      div_start, div_busy;
   logic [oae_pkg::DIV_W-1:0] div_dividend, div_q;

   // helpers
   logic [8:0]    req_sym;
   logic          accept;
   logic [AW-1:0] ctx_base;
   logic          out_free;
   logic          rn_emit, rn_uf, rn_done, rn_cont;
   logic [LW-1:0] nl, nh;
   logic [32:0]   pend_ext, flush_ext;
   logic [PW:0]   pend_p1;
   logic [PW-1:0] flush_pend;
   logic [oae_pkg::FOLLOW_W-1:0] run_follow, flush_follow;
   logic [SW-1:0] hv_half, hv;
   logic [SW-1:0] rd_inc;
   logic          csr_wr;

   assign req_sym  = req_tdata[8:0];
   assign accept   = req_tvalid && (state_ff == oae_pkg::ST_IDLE);
   assign ctx_base = AW'(32'(prev_ff) * ROW);
   assign out_free = !rsp_vld_ff || rsp_tready;
   assign csr_wr   = csr_psel && csr_penable && csr_pwrite &&
                     (csr_paddr[2] == oae_pkg::REG_MAX_SCALE);

   always_comb begin
      rn_emit  = high_ff[LW-1] == low_ff[LW-1];
      rn_uf    = low_ff[LW-2] && !high_ff[LW-2];
      rn_done  = (step_ff == 5'd16) || (!rn_emit && !rn_uf);
      nl       = rn_emit ? {low_ff[LW-2:0], 1'b0} : {1'b0, low_ff[LW-3:0], 1'b0};
      nh       = rn_emit ? {high_ff[LW-2:0], 1'b1} : {1'b1, high_ff[LW-3:0], 1'b1};
      // once the top bits differ no further run can come out of this symbol
      rn_cont  = (step_ff != 5'd15) && (nh[LW-1] == nl[LW-1]);
      pend_ext   = 33'(pend_ff);
      run_follow = (pend_ext > 33'hffff) ? 16'hffff : pend_ext[15:0];
      pend_p1    = {1'b0, pend_ff} + 1'b1;
      flush_pend = pend_p1[PW] ? {PW{1'b1}} : pend_p1[PW-1:0];
      flush_ext  = 33'(flush_pend);
      flush_follow = (flush_ext > 33'hffff) ? 16'hffff : flush_ext[15:0];
      hv_half  = {1'b0, rdata_ff[SW-1:1]};
      hv       = (hv_half <= hprev_ff) ? hprev_ff + 1'b1 : hv_half;
      rd_inc   = rdata_ff + 1'b1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         oae_pkg::ST_CLEAR: begin
            if (clr_addr_ff == LAST_ADDR) state_in = oae_pkg::ST_IDLE;
         end
         oae_pkg::ST_IDLE: begin
            if (accept && req_sym <= EOS_SYM) state_in = oae_pkg::ST_RD_HI;
         end
         oae_pkg::ST_RD_HI:       state_in = oae_pkg::ST_RD_TOP;
         oae_pkg::ST_RD_TOP:      state_in = oae_pkg::ST_RD_SCALE;
         oae_pkg::ST_RD_SCALE:    state_in = oae_pkg::ST_DIV_HI_GO;
         oae_pkg::ST_DIV_HI_GO:   state_in = oae_pkg::ST_DIV_HI_WAIT;
         oae_pkg::ST_DIV_HI_WAIT: begin
            if (!div_busy) state_in = oae_pkg::ST_DIV_LO_GO;
         end
         oae_pkg::ST_DIV_LO_GO:   state_in = oae_pkg::ST_DIV_LO_WAIT;
         oae_pkg::ST_DIV_LO_WAIT: begin
            if (!div_busy) state_in = oae_pkg::ST_RENORM;
         end
         oae_pkg::ST_RENORM: begin
            if (rn_done) state_in = eos_ff ? oae_pkg::ST_FLUSH : oae_pkg::ST_WALK;
         end
         oae_pkg::ST_FLUSH: begin
            if (out_free && fcnt_ff == 5'd16) state_in = oae_pkg::ST_CLEAR;
         end
         oae_pkg::ST_WALK: begin
            if (idx_ff == TOP_IDX) state_in = oae_pkg::ST_DRAIN;
         end
         oae_pkg::ST_DRAIN: begin
            state_in = half_ff ? oae_pkg::ST_IDLE : oae_pkg::ST_CHECK;
         end
         oae_pkg::ST_CHECK: begin
            state_in = (total_ff >= max_scale_ff) ? oae_pkg::ST_WALK : oae_pkg::ST_IDLE;
         end
         default: state_in = oae_pkg::ST_CLEAR;
      endcase
   end

   // datapath and outputs
   always_comb begin
      sym_in      = sym_ff;
      eos_in      = eos_ff;
      base_in     = base_ff;
      lo_c_in     = lo_c_ff;
      hi_c_in     = hi_c_ff;
      scale_in    = scale_ff;
      range_in    = range_ff;
      q_hi_in     = q_hi_ff;
      low_in      = low_ff;
      high_in     = high_ff;
      pend_in     = pend_ff;
      prev_in     = prev_ff;
      step_in     = step_ff;
      fcnt_in     = fcnt_ff;
      idx_in      = idx_ff;
      wr_vld_in   = 1'b0;
      wr_idx_in   = wr_idx_ff;
      half_in     = half_ff;
      hprev_in    = hprev_ff;
      total_in    = total_ff;
      clr_addr_in = clr_addr_ff;
      clr_idx_in  = clr_idx_ff;
      rsp_vld_in  = rsp_tready ? 1'b0 : rsp_vld_ff;
      rsp_lead_in = rsp_lead_ff;
      rsp_cnt_in  = rsp_cnt_ff;
      rsp_last_in = rsp_last_ff;
      mem_raddr   = base_ff;
      mem_we      = 1'b0;
      mem_waddr   = base_ff + AW'(wr_idx_ff);
      mem_wdata   = half_ff ? hv : rd_inc;
      div_start   = 1'b0;
      div_dividend = oae_pkg::DIV_W'(range_ff * hi_c_ff);

      // pipelined write-back of the walk
      if (wr_vld_ff) begin
         mem_we = 1'b1;
         if (half_ff) begin
            hprev_in = hv;
         end else if (wr_idx_ff == TOP_IDX) begin
            total_in = rd_inc;
         end
      end

      unique case (state_ff)
         oae_pkg::ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = SW'(clr_idx_ff);
            clr_addr_in = clr_addr_ff + 1'b1;
            clr_idx_in  = (clr_idx_ff == TOP_IDX) ? '0 : clr_idx_ff + 1'b1;
         end
         oae_pkg::ST_IDLE: begin
            sym_in    = req_sym;
            eos_in    = req_sym == EOS_SYM;
            base_in   = ctx_base;
            mem_raddr = ctx_base + AW'(req_sym);
         end
         oae_pkg::ST_RD_HI: begin
            lo_c_in   = rdata_ff;
            mem_raddr = base_ff + AW'(sym_ff) + 1'b1;
            range_in  = {1'b0, high_ff} - {1'b0, low_ff} + 1'b1;
         end
         oae_pkg::ST_RD_TOP: begin
            hi_c_in   = rdata_ff;
            mem_raddr = base_ff + AW'(TOP_IDX);
         end
         oae_pkg::ST_RD_SCALE: begin
            scale_in = (rdata_ff == '0) ? SW'(1) : rdata_ff;
         end
         oae_pkg::ST_DIV_HI_GO: begin
            div_start = 1'b1;
         end
         oae_pkg::ST_DIV_HI_WAIT: begin
            q_hi_in = div_q[LW-1:0];
         end
         oae_pkg::ST_DIV_LO_GO: begin
            div_start    = 1'b1;
            div_dividend = oae_pkg::DIV_W'(range_ff * lo_c_ff);
         end
         oae_pkg::ST_DIV_LO_WAIT: begin
            if (!div_busy) begin
               high_in = low_ff + q_hi_ff - 1'b1;
               low_in  = low_ff + div_q[LW-1:0];
               step_in = '0;
            end
         end
         oae_pkg::ST_RENORM: begin
            if (rn_done) begin
               fcnt_in = '0;
               idx_in  = IW'(sym_ff) + 1'b1;
               half_in = 1'b0;
            end else if (rn_emit) begin
               if (out_free) begin
                  rsp_vld_in  = 1'b1;
                  rsp_lead_in = high_ff[LW-1];
                  rsp_cnt_in  = run_follow;
                  rsp_last_in = !eos_ff && !rn_cont;
                  pend_in     = '0;
                  low_in      = nl;
                  high_in     = nh;
                  step_in     = step_ff + 1'b1;
               end
            end else begin
               if (pend_ff != {PW{1'b1}}) pend_in = pend_ff + 1'b1;
               low_in  = nl;
               high_in = nh;
               step_in = step_ff + 1'b1;
            end
         end
         oae_pkg::ST_FLUSH: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_lead_in = (fcnt_ff == '0) ? low_ff[LW-2] : 1'b0;
               rsp_cnt_in  = (fcnt_ff == '0) ? flush_follow : '0;
               rsp_last_in = fcnt_ff == 5'd16;
               fcnt_in     = fcnt_ff + 1'b1;
               if (fcnt_ff == 5'd16) begin
                  low_in      = '0;
                  high_in     = '1;
                  pend_in     = '0;
                  prev_in     = '0;
                  clr_addr_in = '0;
                  clr_idx_in  = '0;
               end
            end
         end
         oae_pkg::ST_WALK: begin
            mem_raddr = base_ff + AW'(idx_ff);
            wr_vld_in = 1'b1;
            wr_idx_in = idx_ff;
            idx_in    = idx_ff + 1'b1;
         end
         oae_pkg::ST_DRAIN: begin
            if (half_ff) prev_in = CW'(sym_ff);
         end
         oae_pkg::ST_CHECK: begin
            if (total_ff >= max_scale_ff) begin
               half_in  = 1'b1;
               idx_in   = IW'(1);
               hprev_in = '0;
            end else begin
               prev_in = CW'(sym_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      max_scale_in = max_scale_ff;
      if (csr_wr) max_scale_in = csr_pwdata[SW-1:0];
   end

   oae_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (scale_ff),
      .busy     (div_busy),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (mem_we) freq_mem[mem_waddr] <= mem_wdata;
      rdata_ff <= freq_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= oae_pkg::ST_CLEAR;
         low_ff       <= '0;
         high_ff      <= '1;
         pend_ff      <= '0;
         prev_ff      <= '0;
         wr_vld_ff    <= 1'b0;
         clr_addr_ff  <= '0;
         clr_idx_ff   <= '0;
         max_scale_ff <= SW'(16383);
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         pend_ff      <= pend_in;
         prev_ff      <= prev_in;
         wr_vld_ff    <= wr_vld_in;
         clr_addr_ff  <= clr_addr_in;
         clr_idx_ff   <= clr_idx_in;
         max_scale_ff <= max_scale_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
      sym_ff      <= sym_in;
      eos_ff      <= eos_in;
      base_ff     <= base_in;
      lo_c_ff     <= lo_c_in;
      hi_c_ff     <= hi_c_in;
      scale_ff    <= scale_in;
      range_ff    <= range_in;
      q_hi_ff     <= q_hi_in;
      step_ff     <= step_in;
      fcnt_ff     <= fcnt_in;
      idx_ff      <= idx_in;
      wr_idx_ff   <= wr_idx_in;
      half_ff     <= half_in;
      hprev_ff    <= hprev_in;
      total_ff    <= total_in;
      rsp_lead_ff <= rsp_lead_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = state_ff == oae_pkg::ST_IDLE;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {7'b0, rsp_cnt_ff, rsp_lead_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == oae_pkg::REG_MAX_SCALE) ?
                       32'(max_scale_ff) : 32'b0;

endmodule

FILE: tb/order1_arith_encoder_tb.sv
// order1_arith_encoder_tb: self-checking bench for the order-1 arithmetic encoder.
// Needs oae_pkg and order1_arith_encoder. A predictor of the coder's runs is held
// in a small class; tasks drive symbols and CSR writes, with random back-pressure.
module order1_arith_encoder_tb;

   localparam int NCTX      = 256;
   localparam int ROW       = NCTX + 2;
   localparam int TOP       = NCTX + 1;
   localparam int EOS_SYM   = NCTX;
   localparam int IDLE_LIMIT = 300000;   // covers the table reload

   typedef struct packed {
      logic        lead;
      logic [15:0] follow;
      logic        last;
   } coded_run_type;

   class run_scoreboard_type;
      logic [13:0] freq [0:NCTX*ROW-1];
      logic [15:0] low, high, pending;
      int          prev_sym;
      logic [13:0] max_scale;
      coded_run_type runs_due [$];
      coded_run_type beat_runs [$];
      int          errors;

      function void stream_clear();
         for (int c = 0; c < NCTX; c++)
            for (int i = 0; i < ROW; i++)
               freq[c*ROW + i] = i[13:0];
         low = 16'h0000;
         high = 16'hffff;
         pending = 16'd0;
         prev_sym = 0;
      endfunction

      function new();
         max_scale = 14'd16383;
         errors = 0;
         stream_clear();
      endfunction

      function void emit(logic bit_v, logic [15:0] follow);
         coded_run_type r;
         r.lead = bit_v;
         r.follow = follow;
         r.last = 1'b0;
         beat_runs.push_back(r);
      endfunction

      function void narrow(int unsigned lo_c, int unsigned hi_c, int unsigned scale);
         int unsigned span;
         logic [15:0] base_lo;
         span = int'(high) - int'(low) + 1;
         base_lo = low;
         if (scale == 0) scale = 1;
         high = 16'(base_lo + (span * hi_c) / scale - 1);
         low  = 16'(base_lo + (span * lo_c) / scale);
         for (int s = 0; s < 16; s++) begin
            if (high[15] == low[15]) begin
               emit(high[15], pending);
               pending = 16'd0;
            end else if (low[14] && !high[14]) begin
               if (pending != 16'hffff) pending++;
               low  = low & 16'h3fff;
               high = high | 16'h4000;
            end else begin
               return;
            end
            low  = low << 1;
            high = (high << 1) | 16'd1;
         end
      endfunction

      function void bump_counts(int base, int sym);
         logic [13:0] v;
         for (int i = sym + 1; i <= TOP; i++)
            freq[base + i]++;
         if (freq[base + TOP] < max_scale) return;
         for (int i = 1; i <= TOP; i++) begin
            v = freq[base + i] >> 1;
            if (v <= freq[base + i - 1]) v = freq[base + i - 1] + 14'd1;
            freq[base + i] = v;
         end
      endfunction

      // accepted req beat: work out the runs it causes
      function void note_symbol(logic [8:0] sym);
         int base;
         logic [16:0] f;
         coded_run_type r;
         if (sym > EOS_SYM) return;
         base = prev_sym * ROW;
         beat_runs.delete();
         narrow(freq[base + sym], freq[base + sym + 1], freq[base + TOP]);
         if (sym == EOS_SYM) begin
            f = {1'b0, pending} + 17'd1;
            emit(low[14], f[16] ? 16'hffff : f[15:0]);
            for (int k = 0; k < 16; k++) emit(1'b0, 16'd0);
            stream_clear();
         end else begin
            bump_counts(base, int'(sym));
            prev_sym = int'(sym);
         end
         if (beat_runs.size() > 0) begin
            r = beat_runs.pop_back();
            r.last = 1'b1;
            beat_runs.push_back(r);
         end
         foreach (beat_runs[i]) runs_due.push_back(beat_runs[i]);
      endfunction

      function void check_run(logic lead, logic [15:0] follow, logic last);
         coded_run_type e;
         if (runs_due.size() == 0) begin
            $display("%0t: unexpected run lead=%0d follow=%0d last=%0d",
                     $time, lead, follow, last);
            errors++;
            return;
         end
         e = runs_due.pop_front();
         if (lead !== e.lead) begin
            $display("%0t: lead_bit exp %0d got %0d", $time, e.lead, lead);
            errors++;
         end
         if (follow !== e.follow) begin
            $display("%0t: follow_count exp %0d got %0d", $time, e.follow, follow);
            errors++;
         end
         if (last !== e.last) begin
            $display("%0t: tlast exp %0d got %0d", $time, e.last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [15:0] req_tdata;      // [8:0] symbol
   logic        rsp_tvalid, rsp_tready;
   logic [23:0] rsp_tdata;      // [0] lead_bit, [16:1] follow_count
   logic        rsp_tlast;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic        csr_pready;

   run_scoreboard_type runs = new();
   bit calm = 0;
   int idle_cycles = 0;
   int eos_sent = 0;

   order1_arith_encoder dut (.*);

   initial clock = 0;
   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // beat monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) runs.note_symbol(req_tdata[8:0]);
         if (rsp_tvalid && rsp_tready)
            runs.check_run(rsp_tdata[0], rsp_tdata[16:1], rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // receiver stalls in bursts
   initial begin
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   task automatic send_symbol(input logic [8:0] sym);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, sym};
      if (sym == EOS_SYM) eos_sent++;
      do @(posedge clock); while (!req_tready);
   endtask

   // hold off until every run is in, then let any runless work finish
   task automatic drain();
      req_tvalid <= 1'b0;
      while (runs.runs_due.size() != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
   endtask

   task automatic write_max_scale(input logic [13:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {oae_pkg::REG_MAX_SCALE, 2'b00};
      csr_pwdata  <= {18'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      runs.max_scale = value;
   endtask

   task automatic random_block(input int count);
      int pick;
      logic [8:0] hot [8];
      foreach (hot[i]) hot[i] = 9'($urandom_range(0, 255));
      for (int n = 0; n < count; n++) begin
         pick = int'($urandom_range(0, 99));
         if (pick < 60)      send_symbol(hot[$urandom_range(0, 7)]);
         else if (pick < 88) send_symbol(9'($urandom_range(0, 255)));
         else if (pick < 96) send_symbol(9'($urandom_range(257, 511)));
         else if (eos_sent < 6) send_symbol(9'(EOS_SYM));
         else                send_symbol(9'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      logic [8:0] directed [] = '{9'd0, 9'd255, 9'd511, 9'd257, 9'd0, 9'd0, 9'd0,
                                  9'd0, 9'd255, 9'd255, 9'd128, 9'd1, 9'd170,
                                  9'd85, 9'd384, 9'd256, 9'd255, 9'd0, 9'd7,
                                  9'd7, 9'd256};
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= 16'd0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= 3'd0;
      csr_pwdata  <= 32'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_symbol(directed[i]);
      drain();

      // smallest scale: halving after every byte
      write_max_scale(14'd258);
      random_block(30);
      send_symbol(9'(EOS_SYM));
      drain();

      write_max_scale(14'd16383);
      random_block(30);
      drain();

      write_max_scale(14'($urandom_range(259, 2000)));
      calm = 1;
      random_block(28);
      send_symbol(9'(EOS_SYM));
      drain();

      runs.errors += runs.runs_due.size();
      if (runs.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
